// ----- hw/rtl/mpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared types and constants for the minimum power sum block.
// ----------------------------------------------------------------------------
package mpsd_pkg;

  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_TERMS = 19;
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPONENT   = 2'd0,
    CFG_BASE_LIMIT = 2'd1,
    CFG_LIST_TERMS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EMIT_ERR   = 2'd0,
    EMIT_COUNT = 2'd1,
    EMIT_TERM  = 2'd2
  } emit_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INIT,
    S_BPOW,
    S_BCHK,
    S_BCMP,
    S_WRITE,
    S_WRD,
    S_WLOAD,
    S_WPOW,
    S_WEMIT,
    S_EMIT_CNT,
    S_EMIT_ERR
  } state_t;

  typedef struct packed {
    logic       load_item;
    logic       rd_prev;
    logic       init_best;
    logic       pow_step;
    logic       rd_cand;
    logic       cmp_cand;
    logic       write_entry;
    logic       rd_walk;
    logic       load_base;
    logic       emit;
    emit_kind_t emit_kind;
  } cmd_t;

  typedef struct packed {
    logic order_ok;
    logic pow_done;
    logic cand_stop;
    logic walk_end;
    logic out_free;
  } stat_t;

endpackage

// ----- hw/rtl/min_power_sum_dp.sv -----
// ----------------------------------------------------------------------------
// min_power_sum_dp
// Fewest p-th powers summing to N, built up over N = 1, 2, 3 and upward in order.
// ----------------------------------------------------------------------------
// In-order item: bases b are tried while 2 <= b < base_limit and b^p <= N,
// then one count beat, or in list mode one term beat per term of the chain;
// the next item is accepted after the last beat.
// Out-of-order item: one error beat. A stalled beat holds the sequencer.
// Reset (rst_n low, synchronous): config registers to defaults, expected value 1.
// No clearing pass; table entry zero reads as count zero.
module min_power_sum_dp #(
  parameter int VALUE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // value
  input  logic [((VALUE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // echo_value, term_count, term_base
  output logic [((2*VALUE_BITS+5+7)/8)*8-1:0] out_tdata,
  // status
  output logic                          out_tuser,
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mpsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_BITS:0]           cfg_data
);
  import mpsd_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int OUT_W = ((2 * VB + 5 + 7) / 8) * 8;

  logic [1:0]  exp_m1_r, exp_m1_nxt;
  logic [VB:0] base_limit_r, base_limit_nxt;
  logic        list_terms_r, list_terms_nxt;

  cmd_t             cmd;
  stat_t            stat;
  logic [VB-1:0]    o_echo;
  logic [CNT_W-1:0] o_cnt;
  logic [VB-1:0]    o_base;

  assign cfg_ready = 1'b1;

  always_comb begin
    exp_m1_nxt     = exp_m1_r;
    base_limit_nxt = base_limit_r;
    list_terms_nxt = list_terms_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_EXPONENT: begin
          if (cfg_data[2:0] == 3'd0) begin
            exp_m1_nxt = 2'd0;
          end else if (cfg_data[2:0] > 3'd4) begin
            exp_m1_nxt = 2'd3;
          end else begin
            exp_m1_nxt = 2'(cfg_data[2:0] - 3'd1);
          end
        end
        CFG_BASE_LIMIT: base_limit_nxt = cfg_data;
        CFG_LIST_TERMS: list_terms_nxt = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_m1_r     <= 2'd1;
      base_limit_r <= (VB+1)'(1 << VB);
      list_terms_r <= 1'b1;
    end else begin
      exp_m1_r     <= exp_m1_nxt;
      base_limit_r <= base_limit_nxt;
      list_terms_r <= list_terms_nxt;
    end
  end

  mpsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .list_terms (list_terms_r),
    .stat       (stat),
    .cmd        (cmd)
  );

  mpsd_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (in_tdata[VB-1:0]),
    .exp_m1     (exp_m1_r),
    .base_limit (base_limit_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_echo   (o_echo),
    .out_count  (o_cnt),
    .out_base   (o_base),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

  assign out_tdata = OUT_W'({o_base, o_cnt, o_echo});

endmodule

// ----- hw/rtl/mpsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpsd_ctrl
// Sequencer: base search, table write, chain walk and result beats.
// ----------------------------------------------------------------------------
module mpsd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          list_terms,
  input  mpsd_pkg::stat_t stat,
  output mpsd_pkg::cmd_t  cmd
);
  import mpsd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.order_ok) begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INIT;
        end else begin
          state_nxt = S_EMIT_ERR;
        end
      end
      S_INIT: begin
        cmd.init_best = 1'b1;
        state_nxt     = S_BPOW;
      end
      S_BPOW: begin
        if (stat.pow_done) begin
          state_nxt = S_BCHK;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      S_BCHK: begin
        if (stat.cand_stop) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.rd_cand = 1'b1;
          state_nxt   = S_BCMP;
        end
      end
      S_BCMP: begin
        cmd.cmp_cand = 1'b1;
        state_nxt    = S_BPOW;
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        state_nxt       = list_terms ? S_WRD : S_EMIT_CNT;
      end
      S_WRD: begin
        cmd.rd_walk = 1'b1;
        state_nxt   = S_WLOAD;
      end
      S_WLOAD: begin
        cmd.load_base = 1'b1;
        state_nxt     = S_WPOW;
      end
      S_WPOW: begin
        if (stat.pow_done) begin
          state_nxt = S_WEMIT;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      S_WEMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_TERM;
          state_nxt     = stat.walk_end ? S_IDLE : S_WRD;
        end
      end
      S_EMIT_CNT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_COUNT;
          state_nxt     = S_IDLE;
        end
      end
      S_EMIT_ERR: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_ERR;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/mpsd_dp.sv -----
// ----------------------------------------------------------------------------
// mpsd_dp
// Datapath: count/base table, power unit, best tracking, output register.
// ----------------------------------------------------------------------------
module mpsd_dp #(
  parameter int VALUE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpsd_pkg::cmd_t                cmd,
  output mpsd_pkg::stat_t               stat,
  input  logic [VALUE_BITS-1:0]         in_value,
  input  logic [1:0]                    exp_m1,
  input  logic [VALUE_BITS:0]           base_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [VALUE_BITS-1:0]         out_echo,
  output logic [mpsd_pkg::CNT_W-1:0]    out_count,
  output logic [VALUE_BITS-1:0]         out_base,
  output logic                          out_last,
  output logic                          out_status
);
  import mpsd_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int DEPTH = 1 << VB;
  localparam int ENT_W = CNT_W + VB;
  localparam int PRD_W = 2 * VB + 1;

  // table: {count, base}
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_q_r;
  logic             rd_zero_r;
  logic             rd_en;
  logic [VB-1:0]    rd_addr;

  logic [VB-1:0]    n_r, n_nxt;
  logic [VB-1:0]    expected_r, expected_nxt;
  logic [CNT_W-1:0] best_r, best_nxt;
  logic [VB-1:0]    first_r, first_nxt;
  logic [VB:0]      b_r, b_nxt;
  logic [VB:0]      acc_r, acc_nxt;
  logic [VB-1:0]    mbase_r, mbase_nxt;
  logic [1:0]       mul_k_r, mul_k_nxt;
  logic [VB-1:0]    next_r, next_nxt;
  logic [CNT_W-1:0] term_k_r, term_k_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [VB-1:0]    o_echo_r, o_echo_nxt;
  logic [CNT_W-1:0] o_cnt_r, o_cnt_nxt;
  logic [VB-1:0]    o_base_r, o_base_nxt;
  logic             o_last_r, o_last_nxt;
  logic             o_status_r, o_status_nxt;

  logic [CNT_W-1:0] rd_cnt;
  logic [VB-1:0]    rd_base;
  logic [CNT_W-1:0] cnt_inc;
  logic [PRD_W-1:0] prod;
  logic [VB:0]      acc_mul;
  logic [VB:0]      b_inc;
  logic [VB-1:0]    n_inc;
  logic [VB-1:0]    next_val;
  logic             walk_end;

  assign rd_cnt  = rd_zero_r ? '0 : rd_q_r[ENT_W-1:VB];
  assign rd_base = rd_q_r[VB-1:0];
  assign cnt_inc = (rd_cnt == COUNT_MAX) ? COUNT_MAX : rd_cnt + 1'b1;
  assign prod    = PRD_W'(acc_r) * PRD_W'(mbase_r);
  assign acc_mul = (|prod[PRD_W-1:VB+1]) ? '1 : prod[VB:0];
  assign b_inc   = b_r + 1'b1;
  assign n_inc   = n_r + 1'b1;

  assign next_val = (acc_r == '0 || acc_r >= {1'b0, next_r}) ? '0
                  : next_r - acc_r[VB-1:0];
  assign walk_end = (next_val == '0) || (term_k_r == CNT_W'(MAX_TERMS - 1));

  assign stat.order_ok  = (n_r != '0) && (n_r == expected_r);
  assign stat.pow_done  = (mul_k_r == exp_m1);
  assign stat.cand_stop = (b_r >= base_limit) || b_r[VB] || (acc_r > {1'b0, n_r});
  assign stat.walk_end  = walk_end;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign rd_en = cmd.rd_prev || cmd.rd_cand || cmd.rd_walk;

  always_comb begin
    if (cmd.rd_prev) begin
      rd_addr = n_r - 1'b1;
    end else if (cmd.rd_cand) begin
      rd_addr = n_r - acc_r[VB-1:0];
    end else begin
      rd_addr = next_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem[n_r] <= {best_r, first_r};
    end
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_zero_r <= (rd_addr == '0);
    end
  end

  always_comb begin
    n_nxt        = n_r;
    expected_nxt = expected_r;
    best_nxt     = best_r;
    first_nxt    = first_r;
    b_nxt        = b_r;
    acc_nxt      = acc_r;
    mbase_nxt    = mbase_r;
    mul_k_nxt    = mul_k_r;
    next_nxt     = next_r;
    term_k_nxt   = term_k_r;

    if (cmd.load_item) begin
      n_nxt = in_value;
    end
    if (cmd.init_best) begin
      best_nxt  = cnt_inc;
      first_nxt = VB'(1);
      b_nxt     = (VB+1)'(2);
      acc_nxt   = (VB+1)'(2);
      mbase_nxt = VB'(2);
      mul_k_nxt = '0;
    end
    if (cmd.pow_step) begin
      acc_nxt   = acc_mul;
      mul_k_nxt = mul_k_r + 1'b1;
    end
    if (cmd.cmp_cand) begin
      if (cnt_inc <= best_r) begin
        best_nxt  = cnt_inc;
        first_nxt = b_r[VB-1:0];
      end
      b_nxt     = b_inc;
      acc_nxt   = b_inc;
      mbase_nxt = b_inc[VB-1:0];
      mul_k_nxt = '0;
    end
    if (cmd.write_entry) begin
      expected_nxt = n_inc;
      next_nxt     = n_r;
      term_k_nxt   = '0;
    end
    if (cmd.load_base) begin
      acc_nxt   = {1'b0, rd_base};
      mbase_nxt = rd_base;
      mul_k_nxt = '0;
    end
    if (cmd.emit && cmd.emit_kind == EMIT_TERM) begin
      next_nxt   = next_val;
      term_k_nxt = term_k_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    o_echo_nxt    = o_echo_r;
    o_cnt_nxt     = o_cnt_r;
    o_base_nxt    = o_base_r;
    o_last_nxt    = o_last_r;
    o_status_nxt  = o_status_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      o_echo_nxt    = n_r;
      case (cmd.emit_kind)
        EMIT_ERR: begin
          o_cnt_nxt    = '0;
          o_base_nxt   = '0;
          o_last_nxt   = 1'b1;
          o_status_nxt = 1'b1;
        end
        EMIT_COUNT: begin
          o_cnt_nxt    = best_r;
          o_base_nxt   = '0;
          o_last_nxt   = 1'b1;
          o_status_nxt = 1'b0;
        end
        EMIT_TERM: begin
          o_cnt_nxt    = best_r;
          o_base_nxt   = mbase_r;
          o_last_nxt   = walk_end;
          o_status_nxt = 1'b0;
        end
        default: begin
          o_cnt_nxt    = '0;
          o_base_nxt   = '0;
          o_last_nxt   = 1'b1;
          o_status_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= VB'(1);
      out_valid_r <= 1'b0;
    end else begin
      expected_r  <= expected_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    best_r     <= best_nxt;
    first_r    <= first_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    mbase_r    <= mbase_nxt;
    mul_k_r    <= mul_k_nxt;
    next_r     <= next_nxt;
    term_k_r   <= term_k_nxt;
    o_echo_r   <= o_echo_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_base_r   <= o_base_nxt;
    o_last_r   <= o_last_nxt;
    o_status_r <= o_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_echo   = o_echo_r;
  assign out_count  = o_cnt_r;
  assign out_base   = o_base_r;
  assign out_last   = o_last_r;
  assign out_status = o_status_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("beat loaded over a pending beat");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_entry |-> (best_r != '0))
    else $error("zero count written");

  a_expected_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_entry |=> (expected_r == $past(n_inc)))
    else $error("expected value not advanced");

  a_cand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_cand |-> (acc_r <= {1'b0, n_r}))
    else $error("candidate power above value");

endmodule
